### src/npc_pkg.sv
// Package for the nearest palette color unit.
// Holds shared types, operation and register codes, and field widths.
// No dependencies.
package npc_pkg;

  localparam int COLOR_W    = 24;
  localparam int INDEX_W    = 8;
  localparam int COUNT_W    = 9;
  localparam int DIST_W     = 18;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 9;

  localparam logic [COUNT_W-1:0] PALETTE_COUNT_RESET = 9'd256;

  // Operation codes of a request
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_PALETTE_COUNT = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_SWAP_RED_BLUE = 1'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic in_ready;
    logic write_entry;
    logic start;
    logic issue;
    logic load_out;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_end;
    logic pipe_busy;
    logic out_free;
  } sts_t;

endpackage

### src/npc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; contents are undefined until written.
module npc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/npc_ctrl.sv
// Controller state machine for the nearest palette color unit.
// Depends on npc_pkg for state, command and status types.
module npc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          operation_i,
  input  npc_pkg::sts_t sts_i,
  output npc_pkg::cmd_t cmd_o
);

  npc_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= npc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      npc_pkg::ST_IDLE: begin
        if (in_valid_i && operation_i == npc_pkg::OP_LOOKUP) begin
          state_d = npc_pkg::ST_ISSUE;
        end
      end
      npc_pkg::ST_ISSUE: begin
        if (sts_i.scan_end) begin
          state_d = npc_pkg::ST_DRAIN;
        end
      end
      npc_pkg::ST_DRAIN: begin
        if (!sts_i.pipe_busy) begin
          state_d = npc_pkg::ST_FINISH;
        end
      end
      npc_pkg::ST_FINISH: begin
        if (sts_i.out_free) begin
          state_d = npc_pkg::ST_IDLE;
        end
      end
      default: state_d = npc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      npc_pkg::ST_IDLE: begin
        cmd_o.in_ready    = 1'b1;
        cmd_o.write_entry = in_valid_i && operation_i == npc_pkg::OP_WRITE;
        cmd_o.start       = in_valid_i && operation_i == npc_pkg::OP_LOOKUP;
      end
      npc_pkg::ST_ISSUE: begin
        cmd_o.issue = !sts_i.scan_end;
      end
      npc_pkg::ST_DRAIN: begin
        cmd_o = '0;
      end
      npc_pkg::ST_FINISH: begin
        cmd_o.load_out = sts_i.out_free;
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

### src/npc_datapath.sv
// Datapath: configuration registers, palette RAM, distance pipeline, best-match tracking
// and the output register. Depends on npc_pkg and npc_ram.
module npc_datapath #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [npc_pkg::CFG_ADDR_W-1:0]  cfg_addr_i,
  input  logic [npc_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic [npc_pkg::INDEX_W-1:0]     entry_index_i,
  input  logic [npc_pkg::COLOR_W-1:0]     color_i,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output logic [npc_pkg::INDEX_W-1:0]     palette_index_o,
  input  npc_pkg::cmd_t                   cmd_i,
  output npc_pkg::sts_t                   sts_o
);

  localparam int ADDR_W = $clog2(PALETTE_DEPTH);
  localparam int CNT_W  = $clog2(PALETTE_DEPTH + 1);

  // Configuration
  logic [npc_pkg::COUNT_W-1:0] count_q;
  logic                        swap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= npc_pkg::PALETTE_COUNT_RESET;
      swap_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        npc_pkg::REG_PALETTE_COUNT: count_q <= cfg_wdata_i;
        npc_pkg::REG_SWAP_RED_BLUE: swap_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Request decode
  logic                        wr_en;
  logic [npc_pkg::COLOR_W-1:0] src_d;
  logic [CNT_W-1:0]            n_d;

  assign wr_en = cmd_i.write_entry &&
                 ({1'b0, entry_index_i} < 9'(PALETTE_DEPTH));
  assign src_d = swap_q ? {color_i[7:0], color_i[15:8], color_i[23:16]} : color_i;
  assign n_d   = (count_q > 9'(PALETTE_DEPTH)) ? CNT_W'(PALETTE_DEPTH)
                                                : CNT_W'(count_q);

  // Scan counter
  logic [npc_pkg::COLOR_W-1:0] src_q;
  logic [CNT_W-1:0]            cnt_q, n_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      n_q   <= '0;
    end else if (cmd_i.start) begin
      cnt_q <= '0;
      n_q   <= n_d;
    end else if (cmd_i.issue) begin
      cnt_q <= cnt_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      src_q <= src_d;
    end
  end

  // Palette store
  logic [npc_pkg::COLOR_W-1:0] ram_rdata;

  npc_ram #(
    .WIDTH (npc_pkg::COLOR_W),
    .DEPTH (PALETTE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (entry_index_i[ADDR_W-1:0]),
    .wdata_i (color_i),
    .re_i    (cmd_i.issue),
    .raddr_i (cnt_q[ADDR_W-1:0]),
    .rdata_o (ram_rdata)
  );

  // Distance stage
  logic [7:0]                 diff2, diff1, diff0;
  logic [15:0]                sq2, sq1, sq0;
  logic [npc_pkg::DIST_W-1:0] dist_d;

  always_comb begin
    diff2  = (src_q[23:16] > ram_rdata[23:16]) ? src_q[23:16] - ram_rdata[23:16]
                                                : ram_rdata[23:16] - src_q[23:16];
    diff1  = (src_q[15:8] > ram_rdata[15:8]) ? src_q[15:8] - ram_rdata[15:8]
                                              : ram_rdata[15:8] - src_q[15:8];
    diff0  = (src_q[7:0] > ram_rdata[7:0]) ? src_q[7:0] - ram_rdata[7:0]
                                            : ram_rdata[7:0] - src_q[7:0];
    sq2    = {8'd0, diff2} * {8'd0, diff2};
    sq1    = {8'd0, diff1} * {8'd0, diff1};
    sq0    = {8'd0, diff0} * {8'd0, diff0};
    dist_d = npc_pkg::DIST_W'(sq2) + npc_pkg::DIST_W'(sq1) + npc_pkg::DIST_W'(sq0);
  end

  logic                       rd_vld_q, dist_vld_q;
  logic [ADDR_W-1:0]          rd_idx_q, dist_idx_q;
  logic [npc_pkg::DIST_W-1:0] dist_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q   <= 1'b0;
      dist_vld_q <= 1'b0;
    end else begin
      rd_vld_q   <= cmd_i.issue;
      dist_vld_q <= rd_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q   <= cnt_q[ADDR_W-1:0];
    dist_idx_q <= rd_idx_q;
    dist_q     <= dist_d;
  end

  // Best-match tracking: first entry at the strict minimum wins
  logic                       found_q;
  logic [ADDR_W-1:0]          best_idx_q;
  logic [npc_pkg::DIST_W-1:0] best_dist_q;
  logic                       take;

  assign take = dist_vld_q && (!found_q || dist_q < best_dist_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q    <= 1'b0;
      best_idx_q <= '0;
    end else if (cmd_i.start) begin
      found_q    <= 1'b0;
      best_idx_q <= '0;
    end else if (take) begin
      found_q    <= 1'b1;
      best_idx_q <= dist_idx_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      best_dist_q <= dist_q;
    end
  end

  // Output register
  logic                        out_valid_q;
  logic [npc_pkg::INDEX_W-1:0] palette_index_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      palette_index_q <= npc_pkg::INDEX_W'(best_idx_q);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign palette_index_o = palette_index_q;

  assign sts_o.scan_end  = (cnt_q == n_q);
  assign sts_o.pipe_busy = rd_vld_q || dist_vld_q;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

endmodule

### src/nearest_palette_color_unit.sv
// Lookup: the result is valid once all n entries are scanned and the pipeline drains,
// with n = min(palette_count, PALETTE_DEPTH); the palette RAM read port feeds one entry
// per cycle. A new request is accepted the cycle after the result registers; write
// requests are accepted every cycle while idle and give no result.
// Reset clears control, palette_count to 256 and swap to 0; palette contents are
// undefined until written and get no clearing pass.
module nearest_palette_color_unit #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration write port
  input  logic                            cfg_we_i,
  input  logic [npc_pkg::CFG_ADDR_W-1:0]  cfg_addr_i,
  input  logic [npc_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  // Request channel
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            operation_i,
  input  logic [npc_pkg::INDEX_W-1:0]     entry_index_i,
  input  logic [npc_pkg::COLOR_W-1:0]     color_i,
  // Result channel
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [npc_pkg::INDEX_W-1:0]     palette_index_o
);

  npc_pkg::cmd_t cmd;
  npc_pkg::sts_t sts;

  // Sequence each lookup: take the request, issue one RAM read per entry,
  // drain the two-stage distance pipeline, then hand the index to the
  // output register once it is free.
  npc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .operation_i (operation_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Hold the palette and configuration, compute squared distances and
  // keep the first minimum.
  npc_datapath #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .entry_index_i   (entry_index_i),
    .color_i         (color_i),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .palette_index_o (palette_index_o),
    .cmd_i           (cmd),
    .sts_o           (sts)
  );

  assign in_ready_o = cmd.in_ready;

endmodule

### src/npc_checker.sv
// Port-level checker for nearest_palette_color_unit, bound to the top level.
// Depends on npc_pkg for field widths and operation codes.
module npc_checker #(
  parameter int PALETTE_DEPTH = 256
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic                        operation_i,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [npc_pkg::INDEX_W-1:0] palette_index_o
);

  logic lookup_acc, write_acc;

  assign lookup_acc = in_valid_i && in_ready_o && operation_i == npc_pkg::OP_LOOKUP;
  assign write_acc  = in_valid_i && in_ready_o && operation_i == npc_pkg::OP_WRITE;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(palette_index_o))
    else $error("stalled result changed");

  // Stop taking requests while a lookup scans
  a_lookup_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lookup_acc |=> !in_ready_o)
    else $error("request accepted during a scan");

  // Keep taking requests after a write
  a_write_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    write_acc |=> in_ready_o)
    else $error("write blocked the request channel");

  // A new result only appears at the end of a scan
  a_result_from_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared without a scan");

  // Index stays inside the store
  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({1'b0, palette_index_o} < 9'(PALETTE_DEPTH)))
    else $error("palette index beyond depth");

endmodule

bind nearest_palette_color_unit npc_checker #(
  .PALETTE_DEPTH (PALETTE_DEPTH)
) u_npc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .operation_i     (operation_i),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .palette_index_o (palette_index_o)
);
